@@ sv/iee_pkg.sv @@
// Package: constants, types and character codes for the expression evaluator.
package iee_pkg;
    localparam int VALUE_WIDTH_DEF = 48;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int KEY_W           = 8;
    localparam int STATUS_W        = 2;

    localparam logic [KEY_W-1:0] CH_0     = 8'h30;
    localparam logic [KEY_W-1:0] CH_9     = 8'h39;
    localparam logic [KEY_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [KEY_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [KEY_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [KEY_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MATH   = 2'd2;

    typedef enum logic [1:0] {MOP_NONE = 2'd0, MOP_MUL = 2'd1, MOP_DIV = 2'd2} t_mop;
    typedef enum logic [1:0] {AOP_ADD = 2'd0, AOP_SUB = 2'd1, AOP_DISC = 2'd2} t_aop;
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0, PH_NUM = 2'd1, PH_NEED = 2'd2, PH_AFTER = 2'd3
    } t_phase;

    // Request to the serial arithmetic unit
    typedef struct packed {
        logic start;
        logic div;
    } t_alu_req;
endpackage

@@ sv/iee_if.sv @@
// Valid/ready channel interface.
interface iee_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/infix_expression_evaluator_core.sv @@
// Top level: infix keypad expression evaluator, signed fixed point.
// Each character passes through accept, execute and close-out before the next can be
// accepted; a character closing a number that follows '*' or '/' also runs the serial ALU
// (multiply or divide) between execute and close-out, unless it is a divide by zero.
// The result is registered at close-out of the last character, after the ALU run when that
// closes a multiply/divide. Input is held off while a result waits in the output register.
// Synchronous active-low reset returns the parser to its first-character state.
module infix_expression_evaluator_core #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    iee_if.sink   i_in,
    iee_if.source o_out
);
    import iee_pkg::*;
    localparam int VW = VALUE_WIDTH;
    localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_WAIT = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state          r_st;
    logic [KEY_W-1:0] r_c;
    logic            r_last;
    logic [VW-1:0]   r_sum, r_prod, r_num;
    t_mop            r_mop;
    t_aop            r_aop;
    logic            r_neg, r_esyn, r_ediv;
    t_phase          r_ph;
    logic            r_ovalid;
    logic [STATUS_W-1:0] r_ostat;
    logic [VW-1:0]   r_oval;
    logic            r_tail;   // term close due; on the last char, after the final ALU op

    t_alu_req        alu_req;
    logic            alu_done;
    logic [VW-1:0]   alu_res, nval;

    iee_alu #(.VW(VW), .FB(FRAC_BITS)) u_alu (
        .i_clk, .i_rst_n, .i_req(alu_req), .i_a(r_prod), .i_b(nval),
        .o_done(alu_done), .o_res(alu_res)
    );

    function automatic logic [VW-1:0] sadd(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) return s[VW] ? MINV : MAXV;
        return s[VW-1:0];
    endfunction
    function automatic logic [VW-1:0] ssub(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1]) return s[VW] ? MINV : MAXV;
        return s[VW-1:0];
    endfunction

    logic is_dig;
    logic [VW+3:0] x10;
    logic [VW-1:0] ndig, v10;
    assign is_dig = (r_c >= CH_0) && (r_c <= CH_9);
    assign nval   = r_neg ? ((r_num == MINV) ? MAXV : (~r_num + 1'b1)) : r_num;
    // number*10 as shift-and-add, saturating
    assign x10 = ({{4{r_num[VW-1]}}, r_num} << 3) + ({{4{r_num[VW-1]}}, r_num} << 1);
    assign v10 = ($signed(r_num) > $signed(MAXV / 10)) ? MAXV
               : ((x10[VW+3:VW-1] == '0 || x10[VW+3:VW-1] == '1) ? x10[VW-1:0] : MINV);
    assign ndig = sadd(v10, VW'(r_c - CH_0) << FRAC_BITS);

    assign i_in.ready  = (r_st == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = {r_ostat, r_oval};

    // term being closed: the pending number on a plain last digit, else the product term
    logic [VW-1:0] cterm, tsum;
    assign cterm = (r_last && !r_tail) ? nval : r_prod;
    always_comb begin
        unique case (r_aop)
            AOP_ADD: tsum = sadd(r_sum, cterm);
            AOP_SUB: tsum = ssub(r_sum, cterm);
            default: tsum = r_sum;
        endcase
    end

    // end_number: start ALU if needed, else finish in place
    logic need_alu, exec_alu, exec_close, fin_alu, fin_tail, fin_syn, fin_dz, fin_now;
    logic [STATUS_W-1:0] fin_stat;
    logic [VW-1:0]       fin_val;
    assign need_alu   = (r_mop == MOP_MUL) || (r_mop == MOP_DIV && nval != '0);
    assign exec_alu   = !r_esyn && !is_dig && r_ph == PH_NUM && need_alu;
    assign exec_close = !r_esyn && !is_dig && r_ph == PH_NUM &&
                        r_c != CH_MUL && r_c != CH_DIV;
    // last digit closing a multiply/divide: ALU runs from close-out, then the term closes
    assign fin_alu    = !r_esyn && is_dig && r_ph == PH_NUM && need_alu;
    assign fin_tail   = r_tail && is_dig;
    assign fin_syn    = r_esyn || !(r_ph == PH_NUM || fin_tail);
    assign fin_dz     = r_ediv || (r_ph == PH_NUM && r_mop == MOP_DIV && nval == '0);
    assign fin_stat   = fin_syn ? ST_SYNTAX : (fin_dz ? ST_MATH : ST_OK);
    assign fin_val    = (fin_syn || fin_dz) ? '0 : tsum;
    assign fin_now    = (r_st == S_OUT) && r_last && !fin_alu;

    assign alu_req.start = ((r_st == S_EXEC) && exec_alu) ||
                           ((r_st == S_OUT) && r_last && fin_alu);
    assign alu_req.div   = (r_mop == MOP_DIV);

    // output register: held until its transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin_now) begin
            r_ovalid <= 1'b1;
            r_ostat  <= fin_stat;
            r_oval   <= fin_val;
        end else if (o_out.valid && o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_sum <= '0; r_prod <= '0; r_num <= '0; r_mop <= MOP_NONE; r_aop <= AOP_ADD;
            r_neg <= 1'b0; r_ph <= PH_FIRST; r_esyn <= 1'b0; r_ediv <= 1'b0; r_tail <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_c    <= i_in.data[KEY_W:1];
                        r_last <= i_in.data[0];
                        r_st   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_st   <= exec_alu ? S_WAIT : S_OUT;
                    r_tail <= exec_close;
                    if (!r_esyn) begin
                        if (is_dig) begin
                            r_num <= ndig; r_ph <= PH_NUM;
                        end else begin
                            unique case (r_ph)
                                PH_FIRST: begin
                                    if (r_c == CH_PLUS || r_c == CH_MINUS) begin
                                        r_neg <= (r_c == CH_MINUS); r_ph <= PH_NEED;
                                    end else r_esyn <= 1'b1;
                                end
                                PH_NUM: begin
                                    r_neg <= 1'b0; r_num <= '0; r_ph <= PH_AFTER;
                                    if (r_mop == MOP_DIV && nval == '0) r_ediv <= 1'b1;
                                    else if (r_mop == MOP_NONE) r_prod <= nval;
                                    if (r_c == CH_MUL) r_mop <= MOP_MUL;
                                    else if (r_c == CH_DIV) r_mop <= MOP_DIV;
                                end
                                PH_AFTER: begin
                                    if (r_c == CH_MINUS) begin
                                        r_neg <= 1'b1; r_ph <= PH_NEED;
                                    end else r_esyn <= 1'b1;
                                end
                                default: r_esyn <= 1'b1;
                            endcase
                        end
                    end
                end
                S_WAIT: begin
                    if (alu_done) begin
                        r_prod <= alu_res;
                        r_st   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_last && fin_alu) begin
                        // last digit: run the ALU, come back here to close the term
                        r_st <= S_WAIT; r_ph <= PH_AFTER; r_tail <= 1'b1;
                    end else if (r_last) begin
                        // result goes to the output register; parser back to reset state
                        r_st <= S_IDLE;
                        r_sum <= '0; r_prod <= '0; r_num <= '0; r_mop <= MOP_NONE;
                        r_aop <= AOP_ADD; r_neg <= 1'b0; r_ph <= PH_FIRST;
                        r_esyn <= 1'b0; r_ediv <= 1'b0; r_tail <= 1'b0;
                    end else begin
                        r_st <= S_IDLE;
                        if (r_tail) begin
                            // additive operator (or unknown one) closes the term
                            r_sum <= tsum; r_prod <= '0; r_mop <= MOP_NONE;
                            r_aop <= (r_c == CH_PLUS) ? AOP_ADD
                                   : (r_c == CH_MINUS) ? AOP_SUB : AOP_DISC;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    ap_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
    ap_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != ST_OK) |-> r_oval == '0) else $error("error value");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> r_ovalid) else $error("result dropped");
endmodule

@@ sv/iee_alu.sv @@
// Bit-serial saturating fixed-point multiply and divide of magnitudes.
module iee_alu #(
    parameter int VW = iee_pkg::VALUE_WIDTH_DEF,
    parameter int FB = iee_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iee_pkg::t_alu_req i_req,
    input  logic [VW-1:0]     i_a,
    input  logic [VW-1:0]     i_b,
    output logic              o_done,
    output logic [VW-1:0]     o_res
);
    import iee_pkg::*;
    localparam int PW = 2 * VW + FB;
    localparam int CW = $clog2(PW + 1);
    localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};

    logic          r_busy, r_div, r_neg;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_acc;   // product accumulator / dividend shifter
    logic [VW-1:0] r_x, r_y;
    logic [VW:0]   r_rem;
    logic [PW-1:0] r_q;
    logic [VW-1:0] ma, mb;
    logic [PW-1:0] n_acc;
    logic [VW:0]   n_rem, sub;
    logic [VW:0]   msum;
    logic [PW-1:0] mag;
    logic [VW:0]   lim;

    assign ma = i_a[VW-1] ? (~i_a + 1'b1) : i_a;
    assign mb = i_b[VW-1] ? (~i_b + 1'b1) : i_b;

    // multiply: add y into the upper half when the current x bit is set, then shift right
    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        sub   = '0;
        msum  = '0;
        if (r_div) begin
            n_rem = {r_rem[VW-1:0], r_acc[PW-1]};
            sub   = n_rem - {1'b0, r_y};
        end else begin
            msum  = {1'b0, r_acc[2*VW-1:VW]} + (r_x[0] ? {1'b0, r_y} : '0);
            n_acc = PW'({msum, r_acc[VW-1:1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.div;
                r_neg  <= i_a[VW-1] ^ i_b[VW-1];
                r_y    <= mb;
                r_rem  <= '0;
                r_q    <= '0;
                if (i_req.div) begin
                    r_acc <= PW'(ma) << (PW - VW - FB) + FB;
                    r_cnt <= CW'(VW + FB);
                    r_x   <= '0;
                end else begin
                    r_acc <= '0;
                    r_x   <= ma;
                    r_cnt <= CW'(VW);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_div) begin
                    r_acc <= r_acc << 1;
                    if (!sub[VW]) begin
                        r_rem <= sub;
                        r_q   <= {r_q[PW-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_q   <= {r_q[PW-2:0], 1'b0};
                    end
                end else begin
                    r_acc <= n_acc;
                    r_x   <= r_x >> 1;
                end
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Multiplier consumes x LSB first; full product sits in the low 2*VW bits
    assign mag = r_div ? r_q : (r_acc >> FB);
    assign lim = r_neg ? {1'b0, MAXV} + 1'b1 : {1'b0, MAXV};

    always_comb begin
        if (mag > PW'(lim))
            o_res = r_neg ? ~MAXV : MAXV;
        else
            o_res = r_neg ? (~mag[VW-1:0] + 1'b1) : mag[VW-1:0];
    end

    ap_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("done while busy");
    ap_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("start lost");
    ap_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double done");
endmodule
